FILE: design/fpha_pkg.sv
// Shared types and constants for the fixed-pin HPWL accumulator.
`timescale 1ns / 1ps
package fpha_pkg;

   // Fixed field widths
   localparam int WEIGHT_W    = 16;
   localparam int SCALE_W     = 32;
   localparam int SUM_W       = 64;
   localparam int TOTAL_W     = 63;
   localparam int SPAN_OUT_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_SCALE_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_SCALE_Y = 2'd1;

   // Grid scale of 1.0 in Q16.16
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_PROD,
      ST_ACC,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_DONE
   } fpha_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_pin;
      logic span;
      logic prod;
      logic acc;
      logic scale_lo;
      logic scale_hi;
      logic done;
      logic final_flag;
   } fpha_cmd_type;

   // Status from the channels to the controller
   typedef struct packed {
      logic req_valid;
      logic req_net_end;
      logic req_stream_end;
      logic out_free;
   } fpha_status_type;

endpackage

FILE: design/fpha_req_if.sv
// Pin request channel: valid/ready handshake with one pin per transfer.
`timescale 1ns / 1ps
interface fpha_req_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic                          pin_is_fixed;
   logic signed [COORD_WIDTH-1:0] pin_x;
   logic signed [COORD_WIDTH-1:0] pin_y;
   logic [15:0]                   net_weight;
   logic                          net_end;
   logic                          stream_end;

   modport source (
      output valid, pin_is_fixed, pin_x, pin_y, net_weight, net_end, stream_end,
      input  ready
   );
   modport sink (
      input  valid, pin_is_fixed, pin_x, pin_y, net_weight, net_end, stream_end,
      output ready
   );
endinterface

FILE: design/fpha_rsp_if.sv
// Net result channel: valid/ready handshake with one net result per transfer.
`timescale 1ns / 1ps
interface fpha_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] net_span_x;
   logic [31:0] net_span_y;
   logic        net_had_fixed;
   logic [62:0] total_x;
   logic [62:0] total_y;
   logic        is_final;

   modport source (
      output valid, net_span_x, net_span_y, net_had_fixed, total_x, total_y, is_final,
      input  ready
   );
   modport sink (
      input  valid, net_span_x, net_span_y, net_had_fixed, total_x, total_y, is_final,
      output ready
   );
endinterface

FILE: design/fpha_ctrl.sv
// Sequencer for the per-net close-out: span, weight multiply, accumulate, scale.
`timescale 1ns / 1ps
module fpha_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  fpha_pkg::fpha_status_type status,
   output logic                     req_ready,
   output fpha_pkg::fpha_cmd_type   cmd
);
   import fpha_pkg::*;

   fpha_state_type state_ff, state_in;
   logic           final_ff, final_in;
   logic           req_fire;
   logic           closing;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = status.req_valid && req_ready;
   assign closing   = status.req_net_end || status.req_stream_end;

   // State and stream-end flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   // Remember whether the closing pin also ends the stream
   always_comb begin
      final_in = final_ff;
      if (req_fire) begin
         final_in = status.req_stream_end;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && closing) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN:     state_in = ST_PROD;
         ST_PROD:     state_in = ST_ACC;
         ST_ACC:      state_in = ST_SCALE_LO;
         ST_SCALE_LO: state_in = ST_SCALE_HI;
         ST_SCALE_HI: state_in = ST_DONE;
         ST_DONE: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd            = '0;
      cmd.final_flag = final_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.load_pin = req_fire;
         ST_SPAN:     cmd.span     = 1'b1;
         ST_PROD:     cmd.prod     = 1'b1;
         ST_ACC:      cmd.acc      = 1'b1;
         ST_SCALE_LO: cmd.scale_lo = 1'b1;
         ST_SCALE_HI: cmd.scale_hi = 1'b1;
         ST_DONE:     cmd.done     = status.out_free;
         default:     cmd.done     = 1'b0;
      endcase
   end

   // A closing pin always starts the close-out sequence
   a_close_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && closing) |=> (state_ff == ST_SPAN))
      else $error("closing pin did not start the close-out sequence");

   // A result is only released into a free output register
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      cmd.done |-> status.out_free)
      else $error("result released while output register full");

endmodule

FILE: design/fpha_axis.sv
// One axis of the datapath: pin bounds, span, weighted sum and grid scaling.
`timescale 1ns / 1ps
module fpha_axis #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fpha_pkg::fpha_cmd_type           cmd,
   input  logic                             pin_fixed,
   input  logic signed [COORD_WIDTH-1:0]    pin_coord,
   input  logic                             seen,
   input  logic [fpha_pkg::WEIGHT_W-1:0]    weight,
   input  logic [fpha_pkg::SCALE_W-1:0]     scale,
   output logic [fpha_pkg::SPAN_OUT_W-1:0]  span_out,
   output logic [fpha_pkg::TOTAL_W-1:0]     total
);
   import fpha_pkg::*;

   localparam int PROD_W = COORD_WIDTH + WEIGHT_W;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [COORD_WIDTH-1:0] low_ff, low_in;
   logic signed [COORD_WIDTH-1:0] high_ff, high_in;
   logic [COORD_WIDTH-1:0]        span_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [SUM_W-1:0]              p0_ff;
   logic [SUM_W-1:0]              p1_ff;
   logic [SUM_W:0]                sum_wide;
   logic [SCALE_W-1:0]            mul_a;
   logic [SUM_W-1:0]              mul_res;
   logic [SUM_W-1:0]              comb_sum;
   logic [SUM_W-1:0]              span_ext;

   // Bounds track the fixed pins of the open net
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.span) begin
         low_in  = COORD_MAX;
         high_in = COORD_MIN;
      end else if (cmd.load_pin && pin_fixed) begin
         if (pin_coord < low_ff) begin
            low_in = pin_coord;
         end
         if (pin_coord > high_ff) begin
            high_in = pin_coord;
         end
      end
   end

   // Saturating accumulate, cleared once the stream's last result leaves
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(prod_ff);
      sum_in   = sum_ff;
      if (cmd.acc) begin
         sum_in = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      end else if (cmd.done && cmd.final_flag) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= COORD_MAX;
         high_ff <= COORD_MIN;
         sum_ff  <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         sum_ff  <= sum_in;
      end
   end

   // Shared 32x32 scale multiplier: low half first, then high half
   assign mul_a   = cmd.scale_hi ? sum_ff[SUM_W-1:SCALE_W] : sum_ff[SCALE_W-1:0];
   assign mul_res = mul_a * scale;

   // Span, weighted span and the scale partial products
   always_ff @(posedge clock) begin
      if (cmd.span) begin
         span_ff <= seen ? $unsigned(high_ff - low_ff) : '0;
      end
      if (cmd.prod) begin
         prod_ff <= PROD_W'(span_ff) * PROD_W'(weight);
      end
      if (cmd.scale_lo) begin
         p0_ff <= mul_res;
      end
      if (cmd.scale_hi) begin
         p1_ff <= mul_res;
      end
   end

   // Combine partial products: floor(sum * scale / 2^16), clamped
   assign comb_sum = {p1_ff[47:0], 16'b0} + {16'b0, p0_ff[SUM_W-1:16]};
   assign total    = ((p1_ff[SUM_W-1:47] != '0) || comb_sum[SUM_W-1])
                     ? {TOTAL_W{1'b1}} : comb_sum[TOTAL_W-1:0];

   assign span_ext = SUM_W'(span_ff);
   assign span_out = span_ext[SPAN_OUT_W-1:0];

   // The stream's last result leaves the running sum at zero
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.done && cmd.final_flag) |=> (sum_ff == '0))
      else $error("running sum not cleared after stream end");

endmodule

FILE: design/fixed_pin_hpwl_accumulator.sv
// Top level of the fixed-pin half-perimeter wirelength accumulator.
`timescale 1ns / 1ps
// Usage:
//   req_chan carries one pin per transfer: fixed flag, x/y (signed Q24.8),
//   net weight (Q8.8) and net-end / stream-end marks. Pins with the fixed
//   flag clear only take part in closing a net.
//   rsp_chan returns one result for every pin that ends a net or the stream:
//   the net's x/y spans, whether it held a fixed pin, the running weighted
//   totals scaled by the grid registers (Q.16, saturating) and the final mark.
//   csr_write_en/csr_index/csr_wdata write grid_scale_x (0) and grid_scale_y
//   (1); write them only while the block is idle.
// Timing:
//   While no close-out runs, a pin that does not close a net is taken every
//   cycle. A closing pin runs a 6-step sequence (span, weight multiply,
//   accumulate, two passes through the per-axis 32x32 scale multiplier,
//   combine); its result is then registered, and the next pin is taken in
//   the same cycle in which that result becomes valid.
// Reset (synchronous): bounds empty, totals zero, grid scales 1.0, no result.
// Stall: the result waits in the output register; a further closing pin
//   holds in its combine step until that register has been taken.
module fixed_pin_hpwl_accumulator #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   fpha_req_if.sink                          req_chan,
   fpha_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [fpha_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fpha_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fpha_pkg::*;

   fpha_cmd_type          cmd;
   fpha_status_type       status;
   logic                  req_ready;
   logic [SCALE_W-1:0]    grid_x_ff, grid_x_in;
   logic [SCALE_W-1:0]    grid_y_ff, grid_y_in;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic                  seen_ff, seen_in;
   logic                  had_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SPAN_OUT_W-1:0] span_x, span_y;
   logic [TOTAL_W-1:0]    total_x, total_y;
   logic [SPAN_OUT_W-1:0] rsp_span_x_ff, rsp_span_y_ff;
   logic [TOTAL_W-1:0]    rsp_total_x_ff, rsp_total_y_ff;
   logic                  rsp_had_ff, rsp_final_ff;

   // Channel status toward the controller
   assign status.req_valid      = req_chan.valid;
   assign status.req_net_end    = req_chan.net_end;
   assign status.req_stream_end = req_chan.stream_end;
   assign status.out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready        = req_ready;

   // Configuration registers; unmapped indexes are dropped
   always_comb begin
      grid_x_in = grid_x_ff;
      grid_y_in = grid_y_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_SCALE_X: grid_x_in = csr_wdata;
            CSR_GRID_SCALE_Y: grid_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Fixed-pin flag of the open net
   always_comb begin
      seen_in = seen_ff;
      if (cmd.span) begin
         seen_in = 1'b0;
      end else if (cmd.load_pin && req_chan.pin_is_fixed) begin
         seen_in = 1'b1;
      end
   end

   // Output register valid: set on a new result, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff    <= SCALE_RESET;
         grid_y_ff    <= SCALE_RESET;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_x_ff    <= grid_x_in;
         grid_y_ff    <= grid_y_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: closing weight, net flag and the result
   always_ff @(posedge clock) begin
      if (cmd.load_pin) begin
         weight_ff <= req_chan.net_weight;
      end
      if (cmd.span) begin
         had_ff <= seen_ff;
      end
      if (cmd.done) begin
         rsp_span_x_ff  <= span_x;
         rsp_span_y_ff  <= span_y;
         rsp_had_ff     <= had_ff;
         rsp_total_x_ff <= total_x;
         rsp_total_y_ff <= total_y;
         rsp_final_ff   <= cmd.final_flag;
      end
   end

   fpha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   fpha_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pin_fixed (req_chan.pin_is_fixed),
      .pin_coord (req_chan.pin_x),
      .seen      (seen_ff),
      .weight    (weight_ff),
      .scale     (grid_x_ff),
      .span_out  (span_x),
      .total     (total_x)
   );

   fpha_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pin_fixed (req_chan.pin_is_fixed),
      .pin_coord (req_chan.pin_y),
      .seen      (seen_ff),
      .weight    (weight_ff),
      .scale     (grid_y_ff),
      .span_out  (span_y),
      .total     (total_y)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.net_span_x    = rsp_span_x_ff;
   assign rsp_chan.net_span_y    = rsp_span_y_ff;
   assign rsp_chan.net_had_fixed = rsp_had_ff;
   assign rsp_chan.total_x       = rsp_total_x_ff;
   assign rsp_chan.total_y       = rsp_total_y_ff;
   assign rsp_chan.is_final      = rsp_final_ff;

   // Every released result shows up on the output in the next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> rsp_valid_ff)
      else $error("released result not presented on the output");

endmodule

FILE: sim/fixed_pin_hpwl_accumulator_tb.sv
// Self-checking testbench for the fixed-pin HPWL accumulator: directed, random and stress tests.
`timescale 1ns / 1ps
module fixed_pin_hpwl_accumulator_tb;
   import fpha_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 200;
   localparam int RANDOM_PINS   = 500;
   localparam int CLAMP_NETS    = 40;
   localparam int CYCLE_LIMIT   = 3_000_000;

   localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;

   // Register indexes outside the map; writes to them must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic        fixed;
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] weight;
      logic        net_end;
      logic        stream_end;
   } pin_type;

   typedef struct packed {
      logic [31:0] span_x;
      logic [31:0] span_y;
      logic        had_fixed;
      logic [62:0] total_x;
      logic [62:0] total_y;
      logic        is_final;
   } net_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fpha_req_if #(.COORD_WIDTH(32)) req_chan ();
   fpha_rsp_if                     rsp_chan ();

   fixed_pin_hpwl_accumulator #(.COORD_WIDTH(32)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predicted net state and register copies
   logic [31:0] bound_lo_x, bound_hi_x, bound_lo_y, bound_hi_y;
   logic        seen_fixed;
   logic [63:0] wl_sum_x, wl_sum_y;
   logic [31:0] grid_x, grid_y;
   net_result_type pending_nets[$];

   // Run control and bookkeeping
   bit          sender_gaps;
   bit          rsp_stalls;
   bit          hold_wanted;
   bit          hold_served;
   int          mismatch_count;
   int          pins_offered;
   int          results_seen;
   int          finals_seen;
   int          grid_writes;
   int unsigned cycle_count;

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: run stopped after %0d cycles, %0d nets still pending",
               $time, cycle_count, pending_nets.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   task automatic clear_bounds();
      bound_lo_x = COORD_MAX;
      bound_hi_x = COORD_MIN;
      bound_lo_y = COORD_MAX;
      bound_hi_y = COORD_MIN;
      seen_fixed = 1'b0;
   endtask

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // floor(sum * scale / 2^16), clamped to 63 bits
   function automatic logic [62:0] scaled_total(input logic [63:0] sum,
                                                input logic [31:0] scale);
      logic [95:0] prod;
      prod = {32'd0, sum} * {64'd0, scale};
      if (prod[95:79] != '0) return '1;
      return prod[78:16];
   endfunction

   task automatic absorb_pin(input pin_type p);
      net_result_type r;
      r = '0;
      if (p.fixed) begin
         if ($signed(p.x) < $signed(bound_lo_x)) bound_lo_x = p.x;
         if ($signed(p.x) > $signed(bound_hi_x)) bound_hi_x = p.x;
         if ($signed(p.y) < $signed(bound_lo_y)) bound_lo_y = p.y;
         if ($signed(p.y) > $signed(bound_hi_y)) bound_hi_y = p.y;
         seen_fixed = 1'b1;
      end
      if (!(p.net_end || p.stream_end)) return;
      // net closes: the closing pin's weight applies to the whole net
      r.had_fixed = seen_fixed;
      if (seen_fixed) begin
         r.span_x = bound_hi_x - bound_lo_x;
         r.span_y = bound_hi_y - bound_lo_y;
         wl_sum_x = sat_add64(wl_sum_x, {32'd0, r.span_x} * {48'd0, p.weight});
         wl_sum_y = sat_add64(wl_sum_y, {32'd0, r.span_y} * {48'd0, p.weight});
      end
      r.total_x  = scaled_total(wl_sum_x, grid_x);
      r.total_y  = scaled_total(wl_sum_y, grid_y);
      r.is_final = p.stream_end;
      pending_nets.push_back(r);
      clear_bounds();
      if (p.stream_end) begin
         wl_sum_x = '0;
         wl_sum_y = '0;
      end
   endtask

   // Track register writes and accepted pins
   always @(posedge clock) begin
      pin_type p;
      if (reset) begin
         clear_bounds();
         wl_sum_x = '0;
         wl_sum_y = '0;
         grid_x   = SCALE_RESET;
         grid_y   = SCALE_RESET;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_GRID_SCALE_X: grid_x = csr_wdata;
               CSR_GRID_SCALE_Y: grid_y = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            p.fixed      = req_chan.pin_is_fixed;
            p.x          = req_chan.pin_x;
            p.y          = req_chan.pin_y;
            p.weight     = req_chan.net_weight;
            p.net_end    = req_chan.net_end;
            p.stream_end = req_chan.stream_end;
            absorb_pin(p);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      net_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_nets.size() == 0) begin
            $display("%0t: result with no net pending, expected none actual span %h/%h",
                     $time, rsp_chan.net_span_x, rsp_chan.net_span_y);
            mismatch_count++;
         end else begin
            want = pending_nets.pop_front();
            check_field("net_span_x", 64'(want.span_x), 64'(rsp_chan.net_span_x));
            check_field("net_span_y", 64'(want.span_y), 64'(rsp_chan.net_span_y));
            check_field("net_had_fixed", 64'(want.had_fixed),
                        64'(rsp_chan.net_had_fixed));
            check_field("total_x", 64'(want.total_x), 64'(rsp_chan.total_x));
            check_field("total_y", 64'(want.total_y), 64'(rsp_chan.total_y));
            check_field("is_final", 64'(want.is_final), 64'(rsp_chan.is_final));
            results_seen++;
            if (want.is_final) finals_seen++;
         end
      end
   end

   // ---------------------------------------------------------------- result sink

   // Ready with random stall bursts, plus one long hold on request
   initial begin : rsp_sink
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_served) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served = 1'b1;
            rsp_chan.ready <= 1'b1;
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic pin_type make_pin(input logic fixed, input logic [31:0] x,
                                        input logic [31:0] y, input logic [15:0] weight,
                                        input logic net_end, input logic stream_end);
      pin_type p;
      p.fixed      = fixed;
      p.x          = x;
      p.y          = y;
      p.weight     = weight;
      p.net_end    = net_end;
      p.stream_end = stream_end;
      return p;
   endfunction

   // Leaves valid high so the next pin can follow back to back
   task automatic send_pin(input pin_type p);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.pin_is_fixed <= p.fixed;
      req_chan.pin_x        <= p.x;
      req_chan.pin_y        <= p.y;
      req_chan.net_weight   <= p.weight;
      req_chan.net_end      <= p.net_end;
      req_chan.stream_end   <= p.stream_end;
      req_chan.valid        <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      pins_offered++;
   endtask

   // Drop valid, wait for every pending net result, then let the block settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_nets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both grid registers plus one write to an unmapped index
   task automatic set_grid(input logic [31:0] scale_x, input logic [31:0] scale_y);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_GRID_SCALE_X;
      csr_wdata    <= scale_x;
      @(posedge clock);
      csr_index    <= $urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_wdata    <= $urandom;
      @(posedge clock);
      csr_index    <= CSR_GRID_SCALE_Y;
      csr_wdata    <= scale_y;
      @(posedge clock);
      csr_write_en <= 1'b0;
      grid_writes += 3;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return 32'd0;
               default: return '1;
            endcase
         end
         1, 2, 3, 4: return $urandom_range(0, 8191) - 4096;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_weight();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return '1;
         2: return SCALE_RESET;
         3: return $urandom_range(0, 32'h0003_0000);
         default: return $urandom;
      endcase
   endfunction

   // One net of random size; now and then it closes the stream, sometimes
   // without its own net-end mark
   task automatic send_random_net(input int max_pins);
      int n;
      bit closes_stream;
      bit skip_net_end;
      n             = $urandom_range(1, max_pins);
      closes_stream = ($urandom_range(0, 24) == 0);
      skip_net_end  = closes_stream && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < n; i++)
         send_pin(make_pin($urandom_range(0, 3) != 0, rand_coord(), rand_coord(),
                           rand_weight(), (i == n - 1) && !skip_net_end,
                           (i == n - 1) && closes_stream));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      // single fixed pin at the origin
      send_pin(make_pin(1'b1, 32'd0, 32'd0, 16'h0100, 1'b1, 1'b0));
      // full coordinate range, heaviest weight
      send_pin(make_pin(1'b1, COORD_MIN, COORD_MIN, 16'h0001, 1'b0, 1'b0));
      send_pin(make_pin(1'b1, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b1, 1'b0));
      // net with no fixed pin at all
      send_pin(make_pin(1'b0, COORD_MAX, COORD_MIN, 16'hFFFF, 1'b0, 1'b0));
      send_pin(make_pin(1'b0, COORD_MIN, COORD_MAX, 16'hFFFF, 1'b1, 1'b0));
      // closing pin joins the bounds; its weight is the one used
      send_pin(make_pin(1'b1, 100, -50, 16'hFFFF, 1'b0, 1'b0));
      send_pin(make_pin(1'b1, -300, 400, 16'h0080, 1'b1, 1'b0));
      // non-fixed closing pin leaves the bounds alone
      send_pin(make_pin(1'b1, 5, 5, 16'h0100, 1'b0, 1'b0));
      send_pin(make_pin(1'b0, 1000, 1000, 16'h0200, 1'b1, 1'b0));
      // zero weight
      send_pin(make_pin(1'b1, -1, -1, 16'h0100, 1'b0, 1'b0));
      send_pin(make_pin(1'b1, 1, 7, 16'h0000, 1'b1, 1'b0));
      // stream end without net end closes the net and clears the totals
      send_pin(make_pin(1'b1, 10, 20, 16'h0100, 1'b0, 1'b0));
      send_pin(make_pin(1'b1, 30, -40, 16'h0300, 1'b0, 1'b1));
      send_pin(make_pin(1'b1, 1, 2, 16'h0100, 1'b0, 1'b0));
      send_pin(make_pin(1'b1, 9, -2, 16'h0100, 1'b1, 1'b0));
      // stream end on a net with no fixed pin
      send_pin(make_pin(1'b0, 77, 88, 16'h0100, 1'b1, 1'b1));
      // both marks together on a fixed net
      send_pin(make_pin(1'b1, COORD_MAX, 0, 16'h0100, 1'b0, 1'b0));
      send_pin(make_pin(1'b1, COORD_MAX, 0, 16'h0100, 1'b1, 1'b1));
      wait_drained();
   endtask

   // Extreme and ordinary grid settings, totals left to grow across phases
   task automatic test_grid_settings();
      logic [31:0] scales_x[5];
      logic [31:0] scales_y[5];
      scales_x = '{32'd0, '1, 32'd1, SCALE_RESET, $urandom};
      scales_y = '{'1, 32'd0, 32'h0000_8000, SCALE_RESET, $urandom};
      sender_gaps = 1'b1;
      rsp_stalls  = 1'b1;
      for (int k = 0; k < 5; k++) begin
         set_grid(scales_x[k], scales_y[k]);
         repeat (10) send_random_net(5);
         wait_drained();
      end
   endtask

   task automatic test_random();
      int start;
      start = pins_offered;
      while (pins_offered - start < RANDOM_PINS) begin
         sender_gaps = ($urandom_range(0, 2) != 0);
         rsp_stalls  = ($urandom_range(0, 2) != 0);
         repeat ($urandom_range(8, 20)) begin
            send_random_net(6);
            if ($urandom_range(0, 29) == 0) wait_drained();
         end
         if ($urandom_range(0, 2) == 0) begin
            wait_drained();
            set_grid(rand_scale(), rand_scale());
         end
      end
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering closing pins
   task automatic test_long_stall();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      hold_wanted = 1'b1;
      repeat (16) begin
         send_pin(make_pin(1'b1, rand_coord(), rand_coord(), rand_weight(), 1'b0, 1'b0));
         send_pin(make_pin(1'b1, rand_coord(), rand_coord(), rand_weight(), 1'b1, 1'b0));
      end
      wait_drained();
   endtask

   // Full-span nets under large grid scales: y crosses the scaled-total clamp
   // with its third net, x stays below it
   task automatic test_total_clamp();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      set_grid(32'h0010_0000, 32'h4000_0000);
      repeat (CLAMP_NETS) begin
         send_pin(make_pin(1'b1, COORD_MIN, COORD_MIN, 16'hFFFF, 1'b0, 1'b0));
         send_pin(make_pin(1'b1, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b1, 1'b0));
      end
      send_pin(make_pin(1'b1, 0, 0, 16'hFFFF, 1'b0, 1'b1));
      wait_drained();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main
      req_chan.valid        <= 1'b0;
      req_chan.pin_is_fixed <= 1'b0;
      req_chan.pin_x        <= '0;
      req_chan.pin_y        <= '0;
      req_chan.net_weight   <= '0;
      req_chan.net_end      <= 1'b0;
      req_chan.stream_end   <= 1'b0;
      csr_write_en          <= 1'b0;
      csr_index             <= CSR_GRID_SCALE_X;
      csr_wdata             <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_grid_settings();
      test_random();
      test_long_stall();
      test_total_clamp();

      $display("%0d pins sent, %0d net results checked (%0d closed a stream), %0d errors",
               pins_offered, results_seen, finals_seen, mismatch_count);
      $display("%0d register writes; covered grid extremes, long output stall, total clamp",
               grid_writes);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
